// ----- hdl/pmas_pkg.sv -----
// Shared types, opcodes, status codes and lane masks of the memory access stage.
`default_nettype none

package pmas_pkg;

  // Default data memory depth in 32-bit words.
  localparam int unsigned MEM_WORDS_DEF = 1024;

  // Opcodes seen by the memory stage.
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_MUL     = 6'h1c;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;
  localparam logic [5:0] OP_LL      = 6'h30;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_BUBBLE  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  // Lane masks for sub-word accesses (always the low lane).
  localparam logic [31:0] MASK_BYTE = 32'h0000_00ff;
  localparam logic [31:0] MASK_HALF = 32'h0000_ffff;
  localparam logic [31:0] KEEP_HI3  = 32'hffff_ff00;
  localparam logic [31:0] KEEP_HI2  = 32'hffff_0000;

  // Execute-to-memory latch.
  typedef struct packed {
    logic [31:0] pc_value;
    logic [5:0]  func;
    logic        is_bubble;
    logic [4:0]  rt_index;
    logic [4:0]  rd_index;
    logic [1:0]  dependency_kind;
    logic [31:0] alu_value;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    logic [31:0] mem_address;
    logic [31:0] store_value;
  } item_t;

  // Memory-to-writeback latch.
  typedef struct packed {
    logic [31:0] pc_out;
    logic [31:0] writeback_value;
    logic [31:0] read_data;
    logic [31:0] hi_out;
    logic [31:0] lo_out;
    logic [4:0]  rt_out;
    logic [4:0]  rd_out;
    logic [1:0]  dependency_out;
    logic [1:0]  status;
  } res_t;

  // Data path write request toward the data memory.
  typedef struct packed {
    logic        en;
    logic [31:0] data;
  } wr_req_t;

endpackage

`default_nettype wire

// ----- hdl/pmas_dmem.sv -----
// Synchronous data memory: one write port, one registered read port.
`default_nettype none

module pmas_dmem #(
  parameter int unsigned DEPTH = pmas_pkg::MEM_WORDS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata_r
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a same-address collision; the stage forwards
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pmas_exec.sv -----
// Opcode decode, load lane masking and store merge for one word.
`default_nettype none

module pmas_exec (
  input  wire pmas_pkg::item_t   item,
  input  wire logic [31:0]       word,
  output pmas_pkg::res_t         res,
  output pmas_pkg::wr_req_t      wr
);

  always_comb begin
    res         = '0;
    wr.en       = 1'b0;
    wr.data     = word;
    res.pc_out  = item.pc_value;
    if (item.is_bubble) begin
      res.status = pmas_pkg::ST_BUBBLE;
    end else begin
      res.status         = pmas_pkg::ST_DONE;
      res.rt_out         = item.rt_index;
      res.rd_out         = item.rd_index;
      res.dependency_out = item.dependency_kind;
      case (item.func) inside
        pmas_pkg::OP_SPECIAL, pmas_pkg::OP_MUL: begin
          res.writeback_value = item.alu_value;
          res.hi_out          = item.hi_value;
          res.lo_out          = item.lo_value;
        end
        pmas_pkg::OP_J, pmas_pkg::OP_JAL: begin
          res.read_data       = item.pc_value;
          res.writeback_value = item.alu_value;
        end
        pmas_pkg::OP_ADDI, pmas_pkg::OP_ADDIU, pmas_pkg::OP_SLTI, pmas_pkg::OP_SLTIU,
        pmas_pkg::OP_ANDI, pmas_pkg::OP_ORI, pmas_pkg::OP_LUI: begin
          res.writeback_value = item.alu_value;
        end
        pmas_pkg::OP_BEQ, pmas_pkg::OP_BNE: begin
          // branches only carry the pass-through fields
        end
        pmas_pkg::OP_LW, pmas_pkg::OP_LL: begin
          res.read_data       = word;
          res.writeback_value = word;
        end
        pmas_pkg::OP_LBU: begin
          res.read_data       = word & pmas_pkg::MASK_BYTE;
          res.writeback_value = word & pmas_pkg::MASK_BYTE;
        end
        pmas_pkg::OP_LHU: begin
          res.read_data       = word & pmas_pkg::MASK_HALF;
          res.writeback_value = word & pmas_pkg::MASK_HALF;
        end
        pmas_pkg::OP_SB: begin
          wr.en   = 1'b1;
          wr.data = (word & pmas_pkg::KEEP_HI3) | (item.store_value & pmas_pkg::MASK_BYTE);
          res.read_data       = wr.data;
          res.writeback_value = wr.data;
        end
        pmas_pkg::OP_SH: begin
          wr.en   = 1'b1;
          wr.data = (word & pmas_pkg::KEEP_HI2) | (item.store_value & pmas_pkg::MASK_HALF);
          res.read_data       = wr.data;
          res.writeback_value = wr.data;
        end
        pmas_pkg::OP_SW: begin
          wr.en   = 1'b1;
          wr.data = item.store_value;
          res.read_data       = wr.data;
          res.writeback_value = wr.data;
        end
        default: begin
          res.status = pmas_pkg::ST_UNKNOWN;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pipeline_memory_access_stage_top.sv -----
// Top level of the pipeline memory access stage: index pipeline, data memory and result register.
`default_nettype none

// Memory stage of a five-stage pipeline. While the pipe is not stalled, one
// execute-to-memory word goes in per cycle and one memory-to-writeback word comes
// out per cycle. Each word passes the stages in order: the reciprocal multiply of the
// modulo MEM_WORDS index reduction runs on the incoming word, the next stage multiplies
// back by MEM_WORDS, the one after subtracts and reads the data memory, and the last
// merges/writes back and loads the output register. Throughput is set by the single read and single write port of the
// data memory: one access each per cycle. A store followed at once by a load or
// store to the same word is forwarded, so back-to-back accesses see the new word.
// After reset the memory is cleared one word per cycle; in_stall stays high until
// the clearing pass is done. The whole pipe advances as one: an out_stall while
// out_valid is high holds every stage and raises in_stall. Sub-word loads and stores
// use the low lane of the word; the byte offset of the address is ignored.

module pipeline_memory_access_stage_top #(
  parameter int unsigned MEM_WORDS = pmas_pkg::MEM_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_pc_value,
  input  wire logic [5:0]  in_func,
  input  wire logic        in_is_bubble,
  input  wire logic [4:0]  in_rt_index,
  input  wire logic [4:0]  in_rd_index,
  input  wire logic [1:0]  in_dependency_kind,
  input  wire logic [31:0] in_alu_value,
  input  wire logic [31:0] in_hi_value,
  input  wire logic [31:0] in_lo_value,
  input  wire logic [31:0] in_mem_address,
  input  wire logic [31:0] in_store_value,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_pc_out,
  output logic [31:0]      out_writeback_value,
  output logic [31:0]      out_read_data,
  output logic [31:0]      out_hi_out,
  output logic [31:0]      out_lo_out,
  output logic [4:0]       out_rt_out,
  output logic [4:0]       out_rd_out,
  output logic [1:0]       out_dependency_out,
  output logic [1:0]       out_status
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  // word index = (addr >> 2) % MEM_WORDS via q = floor(x * RCP / 2^SH), exact for 30-bit x
  localparam int unsigned SH = 30 + AW;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
  localparam logic [30:0] RCP  = RECIP[30:0];
  localparam logic [29:0] MW   = 30'(MEM_WORDS);
  localparam logic [AW-1:0] LAST = AW'(MEM_WORDS - 1);

  // ---------------------------------------------------------------- control
  logic          en;        // whole pipe advances
  logic          clr_r;     // clearing pass running
  logic [AW-1:0] clr_cnt_r;
  logic          a_vld_r, b_vld_r, c_vld_r, out_vld_r;

  assign en       = !clr_r && (!out_vld_r || !out_stall);
  assign in_stall = !en;
  assign out_valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == LAST) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= in_valid;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      out_vld_r <= c_vld_r;
    end
  end

  // ---------------------------------------------------------------- stage A: x * RCP
  pmas_pkg::item_t in_item;
  pmas_pkg::item_t a_item_r, b_item_r, c_item_r;
  logic [60:0]     a_prod_r;
  logic [60:0]     a_prod_nxt;

  assign in_item = '{
    pc_value:        in_pc_value,
    func:            in_func,
    is_bubble:       in_is_bubble,
    rt_index:        in_rt_index,
    rd_index:        in_rd_index,
    dependency_kind: in_dependency_kind,
    alu_value:       in_alu_value,
    hi_value:        in_hi_value,
    lo_value:        in_lo_value,
    mem_address:     in_mem_address,
    store_value:     in_store_value
  };

  assign a_prod_nxt = 61'(in_mem_address[31:2]) * 61'(RCP);

  // ---------------------------------------------------------------- stage B: q * MEM_WORDS
  logic [29:0] a_q;
  logic [29:0] b_qm_r;
  logic [29:0] b_qm_nxt;

  assign a_q      = 30'(a_prod_r >> SH);
  assign b_qm_nxt = a_q * MW;

  // ---------------------------------------------------------------- stage C: index, read
  logic [29:0]   b_diff;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] c_idx_r;
  logic          hit_r;     // previous store hit this word while it was read
  logic          hit_nxt;
  logic [31:0]   fwd_r;
  logic [31:0]   ram_q;
  logic [31:0]   c_word;

  assign b_diff = b_item_r.mem_address[31:2] - b_qm_r;
  assign rd_idx = b_diff[AW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      a_item_r <= in_item;
      a_prod_r <= a_prod_nxt;
      b_item_r <= a_item_r;
      b_qm_r   <= b_qm_nxt;
      c_item_r <= b_item_r;
      c_idx_r  <= rd_idx;
    end
  end

  // ---------------------------------------------------------------- modify / write back
  pmas_pkg::res_t    ex_res;
  pmas_pkg::wr_req_t ex_wr;
  logic              dp_we;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata;

  assign c_word = hit_r ? fwd_r : ram_q;

  pmas_exec u_exec (
    .item (c_item_r),
    .word (c_word),
    .res  (ex_res),
    .wr   (ex_wr)
  );

  assign dp_we     = en && c_vld_r && ex_wr.en;
  assign ram_we    = clr_r || dp_we;
  assign ram_waddr = clr_r ? clr_cnt_r : c_idx_r;
  assign ram_wdata = clr_r ? 32'd0 : ex_wr.data;
  // the read issued at this edge misses the write of the same edge
  assign hit_nxt   = dp_we && (c_idx_r == rd_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (en) begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_r <= ex_wr.data;
    end
  end

  pmas_dmem #(
    .DEPTH (MEM_WORDS),
    .AW    (AW)
  ) u_dmem (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (en),
    .raddr   (rd_idx),
    .rdata_r (ram_q)
  );

  // ---------------------------------------------------------------- output register
  pmas_pkg::res_t out_res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= ex_res;
    end
  end

  assign out_pc_out          = out_res_r.pc_out;
  assign out_writeback_value = out_res_r.writeback_value;
  assign out_read_data       = out_res_r.read_data;
  assign out_hi_out          = out_res_r.hi_out;
  assign out_lo_out          = out_res_r.lo_out;
  assign out_rt_out          = out_res_r.rt_out;
  assign out_rd_out          = out_res_r.rd_out;
  assign out_dependency_out  = out_res_r.dependency_out;
  assign out_status          = out_res_r.status;

  // ---------------------------------------------------------------- assertions
  // no data path word moves while the clearing pass owns the write port
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !(a_vld_r || b_vld_r || c_vld_r || out_vld_r))
    else $error("pipeline holds a word during the clearing pass");

  // a freshly loaded forward hit comes from a data path store on that edge
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_r && $past(en)) |-> $past(dp_we))
    else $error("forward hit without a preceding store");

  // bubbles and unknown opcodes never write the memory
  a_no_bad_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (c_vld_r && (c_item_r.is_bubble || ex_res.status == pmas_pkg::ST_UNKNOWN))
      |-> !ex_wr.en)
    else $error("store request from a bubble or unknown opcode");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for the pipeline memory access stage: stimulus, result prediction and checking.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MEM_DEPTH = pmas_pkg::MEM_WORDS_DEF;
  localparam int unsigned RANDOM_WORDS = 450;
  localparam int unsigned QUIET_TAIL = 60;     // last words run with no idling
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;    // pipe is four deep

  // Opcodes that touch the data memory, and those that only pass fields on.
  localparam logic [5:0] MEM_OPS [0:6] = '{
    pmas_pkg::OP_LW, pmas_pkg::OP_LBU, pmas_pkg::OP_LHU, pmas_pkg::OP_LL,
    pmas_pkg::OP_SB, pmas_pkg::OP_SH, pmas_pkg::OP_SW};
  localparam logic [5:0] PASS_OPS [0:12] = '{
    pmas_pkg::OP_SPECIAL, pmas_pkg::OP_MUL, pmas_pkg::OP_J, pmas_pkg::OP_JAL,
    pmas_pkg::OP_BEQ, pmas_pkg::OP_BNE, pmas_pkg::OP_ADDI, pmas_pkg::OP_ADDIU,
    pmas_pkg::OP_SLTI, pmas_pkg::OP_SLTIU, pmas_pkg::OP_ANDI, pmas_pkg::OP_ORI,
    pmas_pkg::OP_LUI};

  // Keeps its own copy of the data memory and the queue of writeback words still owed.
  class stage_scoreboard;
    logic [31:0] mem_copy [MEM_DEPTH];
    pmas_pkg::res_t owed_q [$];
    int unsigned errors;

    function new();
      foreach (mem_copy[i]) mem_copy[i] = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Work out the writeback word for an accepted execute word.
    function void note_input(pmas_pkg::item_t w);
      pmas_pkg::res_t r;
      int unsigned idx;
      r = '0;
      r.pc_out = w.pc_value;
      idx = (w.mem_address >> 2) % MEM_DEPTH;
      if (w.is_bubble) begin
        r.status = pmas_pkg::ST_BUBBLE;
      end else begin
        r.rt_out = w.rt_index;
        r.rd_out = w.rd_index;
        r.dependency_out = w.dependency_kind;
        r.status = pmas_pkg::ST_DONE;
        case (w.func)
          pmas_pkg::OP_SPECIAL, pmas_pkg::OP_MUL: begin
            r.writeback_value = w.alu_value;
            r.hi_out = w.hi_value;
            r.lo_out = w.lo_value;
          end
          pmas_pkg::OP_J, pmas_pkg::OP_JAL: begin
            r.read_data = w.pc_value;
            r.writeback_value = w.alu_value;
          end
          pmas_pkg::OP_ADDI, pmas_pkg::OP_ADDIU, pmas_pkg::OP_SLTI, pmas_pkg::OP_SLTIU,
          pmas_pkg::OP_ANDI, pmas_pkg::OP_ORI, pmas_pkg::OP_LUI: begin
            r.writeback_value = w.alu_value;
          end
          pmas_pkg::OP_BEQ, pmas_pkg::OP_BNE: ;
          pmas_pkg::OP_LW, pmas_pkg::OP_LL: r.read_data = mem_copy[idx];
          pmas_pkg::OP_LBU: r.read_data = mem_copy[idx] & pmas_pkg::MASK_BYTE;
          pmas_pkg::OP_LHU: r.read_data = mem_copy[idx] & pmas_pkg::MASK_HALF;
          pmas_pkg::OP_SB: begin
            mem_copy[idx] = (mem_copy[idx] & pmas_pkg::KEEP_HI3) |
                            (w.store_value & pmas_pkg::MASK_BYTE);
            r.read_data = mem_copy[idx];
          end
          pmas_pkg::OP_SH: begin
            mem_copy[idx] = (mem_copy[idx] & pmas_pkg::KEEP_HI2) |
                            (w.store_value & pmas_pkg::MASK_HALF);
            r.read_data = mem_copy[idx];
          end
          pmas_pkg::OP_SW: begin
            mem_copy[idx] = w.store_value;
            r.read_data = mem_copy[idx];
          end
          default: r.status = pmas_pkg::ST_UNKNOWN;
        endcase
        // memory ops send the word they read or wrote on to writeback as well
        case (w.func)
          pmas_pkg::OP_LW, pmas_pkg::OP_LL, pmas_pkg::OP_LBU, pmas_pkg::OP_LHU,
          pmas_pkg::OP_SB, pmas_pkg::OP_SH, pmas_pkg::OP_SW:
            r.writeback_value = r.read_data;
          default: ;
        endcase
      end
      owed_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %08h, actual %08h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare a writeback word against the oldest one owed.
    function void check_result(pmas_pkg::res_t got);
      pmas_pkg::res_t exp_r;
      if (owed_q.size() == 0) begin
        $error("writeback word with none owed: pc_out %08h", got.pc_out);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      compare_field("pc_out", exp_r.pc_out, got.pc_out);
      compare_field("writeback_value", exp_r.writeback_value, got.writeback_value);
      compare_field("read_data", exp_r.read_data, got.read_data);
      compare_field("hi_out", exp_r.hi_out, got.hi_out);
      compare_field("lo_out", exp_r.lo_out, got.lo_out);
      compare_field("rt_out", 32'(exp_r.rt_out), 32'(got.rt_out));
      compare_field("rd_out", 32'(exp_r.rd_out), 32'(got.rd_out));
      compare_field("dependency_out", 32'(exp_r.dependency_out),
                    32'(got.dependency_out));
      compare_field("status", 32'(exp_r.status), 32'(got.status));
    endfunction
  endclass

  // Every input is known from time zero; after that all driving is nonblocking at posedge.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_pc_value = '0;
  logic [5:0]  in_func = '0;
  logic        in_is_bubble = 1'b0;
  logic [4:0]  in_rt_index = '0;
  logic [4:0]  in_rd_index = '0;
  logic [1:0]  in_dependency_kind = '0;
  logic [31:0] in_alu_value = '0;
  logic [31:0] in_hi_value = '0;
  logic [31:0] in_lo_value = '0;
  logic [31:0] in_mem_address = '0;
  logic [31:0] in_store_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_pc_out;
  logic [31:0] out_writeback_value;
  logic [31:0] out_read_data;
  logic [31:0] out_hi_out;
  logic [31:0] out_lo_out;
  logic [4:0]  out_rt_out;
  logic [4:0]  out_rd_out;
  logic [1:0]  out_dependency_out;
  logic [1:0]  out_status;

  stage_scoreboard sb = new();
  bit quiet = 1'b0;             // no idling on either side once set
  int unsigned gap_pct = 20;    // chance of a sender gap before a word
  int unsigned cycle_count = 0;

  pipeline_memory_access_stage_top #(
    .MEM_WORDS(MEM_DEPTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pc_value(in_pc_value),
    .in_func(in_func),
    .in_is_bubble(in_is_bubble),
    .in_rt_index(in_rt_index),
    .in_rd_index(in_rd_index),
    .in_dependency_kind(in_dependency_kind),
    .in_alu_value(in_alu_value),
    .in_hi_value(in_hi_value),
    .in_lo_value(in_lo_value),
    .in_mem_address(in_mem_address),
    .in_store_value(in_store_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pc_out(out_pc_out),
    .out_writeback_value(out_writeback_value),
    .out_read_data(out_read_data),
    .out_hi_out(out_hi_out),
    .out_lo_out(out_lo_out),
    .out_rt_out(out_rt_out),
    .out_rd_out(out_rd_out),
    .out_dependency_out(out_dependency_out),
    .out_status(out_status)
  );

  always #6 clk = ~clk;

  // Watchdog: CYCLE_LIMIT sits well above the slowest legal run (memory clear plus
  // ~500 words each with the longest sender gap and the longest stall).
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pipeline_memory_access_stage_top test failed");
      $finish;
    end
  end

  // Build a word; fields that the opcode does not care about are all ones or all zeros.
  function automatic pmas_pkg::item_t make_word(logic [5:0] func, logic bubble,
                                                logic [31:0] addr, logic [31:0] sv,
                                                bit ones);
    pmas_pkg::item_t w;
    w = ones ? '1 : '0;
    w.func = func;
    w.is_bubble = bubble;
    w.mem_address = addr;
    w.store_value = sv;
    return w;
  endfunction

  // Random word. Addresses mostly hit a few hot words (with random upper bits
  // that alias away in the modulo) so that loads see earlier stores.
  function automatic pmas_pkg::item_t rand_word();
    pmas_pkg::item_t w;
    int unsigned pick;
    w.pc_value = $urandom;
    w.rt_index = 5'($urandom);
    w.rd_index = 5'($urandom);
    w.dependency_kind = 2'($urandom);
    w.alu_value = $urandom;
    w.hi_value = $urandom;
    w.lo_value = $urandom;
    w.store_value = $urandom;
    w.is_bubble = ($urandom_range(0, 15) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 55) w.func = MEM_OPS[$urandom_range(0, 6)];
    else if (pick < 88) w.func = PASS_OPS[$urandom_range(0, 12)];
    else w.func = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 4) == 0) begin
      w.mem_address = $urandom;
    end else begin
      w.mem_address = $urandom & ~32'h0000_0ffc;
      if ($urandom_range(0, 3) == 0)
        w.mem_address[11:2] = 10'(MEM_DEPTH - 1 - $urandom_range(0, 3));
      else
        w.mem_address[11:2] = 10'($urandom_range(0, 7));
    end
    return w;
  endfunction

  // Optional sender gap of random length, skipped once quiet is set.
  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Present one word and hold it until accepted; valid stays up afterwards.
  task automatic send_word(pmas_pkg::item_t w);
    maybe_gap();
    in_valid <= 1'b1;
    in_pc_value <= w.pc_value;
    in_func <= w.func;
    in_is_bubble <= w.is_bubble;
    in_rt_index <= w.rt_index;
    in_rd_index <= w.rd_index;
    in_dependency_kind <= w.dependency_kind;
    in_alu_value <= w.alu_value;
    in_hi_value <= w.hi_value;
    in_lo_value <= w.lo_value;
    in_mem_address <= w.mem_address;
    in_store_value <= w.store_value;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
  endtask

  // Sender pauses until the pipe has handed back everything owed.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted word, stall in random bursts.
  initial begin
    int unsigned stall_left;
    int unsigned stall_pct;
    int unsigned rx_cycles;
    pmas_pkg::res_t got;
    stall_left = 0;
    stall_pct = 20;
    rx_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.pc_out = out_pc_out;
        got.writeback_value = out_writeback_value;
        got.read_data = out_read_data;
        got.hi_out = out_hi_out;
        got.lo_out = out_lo_out;
        got.rt_out = out_rt_out;
        got.rd_out = out_rd_out;
        got.dependency_out = out_dependency_out;
        got.status = out_status;
        sb.check_result(got);
      end
      rx_cycles++;
      // switch between busy stretches, light and heavy stalling
      if (rx_cycles % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (quiet) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Main sequence: reset, directed words, random words, drain, verdict.
  initial begin
    int unsigned n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Bubble carrying a store: memory must stay untouched and only pc passes.
    send_word(make_word(pmas_pkg::OP_SW, 1'b1, '1, '1, 1'b1));
    send_word(make_word(pmas_pkg::OP_LW, 1'b0, '1, '0, 1'b1));
    // Top word, addressed with every byte offset; sub-word ops use the low lane.
    send_word(make_word(pmas_pkg::OP_SW, 1'b0, '1, '1, 1'b1));
    send_word(make_word(pmas_pkg::OP_SB, 1'b0, 32'hffff_fffc, 32'h0000_0000, 1'b0));
    send_word(make_word(pmas_pkg::OP_SH, 1'b0, 32'hffff_fffe, 32'h1234_0000, 1'b0));
    // aliases to the top word
    send_word(make_word(pmas_pkg::OP_LW, 1'b0, 32'h0000_0ffd, '0, 1'b1));
    // Bottom word: store then load back, next in line unless a sender gap falls between (forwarding path).
    send_word(make_word(pmas_pkg::OP_SW, 1'b0, 32'h0000_0000, 32'h8000_0001, 1'b0));
    send_word(make_word(pmas_pkg::OP_LBU, 1'b0, 32'h0000_0003, '1, 1'b1));
    send_word(make_word(pmas_pkg::OP_LHU, 1'b0, 32'h0000_0002, '1, 1'b0));
    send_word(make_word(pmas_pkg::OP_SB, 1'b0, 32'h0000_0001, '1, 1'b1));
    send_word(make_word(pmas_pkg::OP_SH, 1'b0, 32'h0000_0000, 32'h0000_a5a5, 1'b0));
    send_word(make_word(pmas_pkg::OP_LL, 1'b0, 32'h0000_0000, '0, 1'b1));
    // Pass-through opcodes with all-ones and all-zeros fields.
    foreach (PASS_OPS[i])
      send_word(make_word(PASS_OPS[i], 1'b0, '1, '1, i % 2 == 0));
    // Opcodes the stage does not know.
    send_word(make_word(6'h3f, 1'b0, '1, '1, 1'b1));
    send_word(make_word(6'h01, 1'b0, 32'h0000_0000, '1, 1'b0));
    drain();

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      if (n == RANDOM_WORDS / 2) drain();
      if (n == RANDOM_WORDS - QUIET_TAIL) quiet = 1'b1;
      send_word(rand_word());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("pipeline_memory_access_stage_top test passed");
    end else begin
      $display("pipeline_memory_access_stage_top test failed");
    end
    $finish;
  end

endmodule
